### rtl/idut_pkg.sv
// Shared types, constants and a helper function of the index-to-decimal UUID text block.
package idut_pkg;

   // Digit row geometry.
   localparam int DIGIT_COUNT   = 20;
   localparam int DIGIT_WIDTH   = 4;
   localparam int DIGIT_BITS    = DIGIT_COUNT * DIGIT_WIDTH;
   localparam int INDEX_WIDTH   = 64;
   localparam int BITS_PER_STEP = 2;
   localparam int STEP_COUNT    = INDEX_WIDTH / BITS_PER_STEP;

   // Text geometry.
   localparam int TEXT_LENGTH   = 36;
   localparam int PREFIX_LENGTH = 14;

   typedef logic [DIGIT_WIDTH-1:0]   digit_type;
   typedef logic [DIGIT_BITS-1:0]    digit_row_type;
   typedef logic [INDEX_WIDTH-1:0]   index_type;
   typedef logic [BITS_PER_STEP-1:0] carry_pair_type;
   typedef logic [4:0]               step_type;
   typedef logic [5:0]               pos_type;
   typedef logic [6:0]               char_type;

   localparam step_type STEP_LAST      = step_type'(STEP_COUNT - 1);
   localparam pos_type  TEXT_LAST      = pos_type'(TEXT_LENGTH - 1);
   localparam pos_type  PREFIX_END     = pos_type'(PREFIX_LENGTH);
   localparam pos_type  PREFIX_DASH_A  = pos_type'(8);
   localparam pos_type  PREFIX_DASH_B  = pos_type'(13);
   localparam pos_type  DIGIT_DASH_A   = pos_type'(PREFIX_LENGTH + 4);
   localparam pos_type  DIGIT_DASH_B   = pos_type'(PREFIX_LENGTH + 9);

   localparam char_type ASCII_DASH = char_type'(45);
   localparam char_type ASCII_ZERO = char_type'(48);

   localparam digit_type ADJUST_LIMIT = digit_type'(5);
   localparam digit_type ADJUST_ADD   = digit_type'(3);

   // Converter sequencer states.
   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_RUN,
      CONV_HOLD
   } conv_state_type;

   // Emitter status seen by the converter sequencer.
   typedef struct packed {
      logic active;
      logic finishing;
   } emit_status_type;

   // Character of the fixed prefix "00000000-0000-".
   function automatic char_type prefix_char(pos_type pos);
      char_type result;
      result = ASCII_ZERO;
      if ((pos == PREFIX_DASH_A) || (pos == PREFIX_DASH_B)) begin
         result = ASCII_DASH;
      end
      return result;
   endfunction

endpackage

### rtl/idut_cell.sv
// One BCD digit cell of the double dabble row: adjusts and shifts two bits per cycle while enabled.
module idut_cell (
   input  logic                     clock,
   input  logic                     clear,
   input  logic                     enable,
   input  idut_pkg::carry_pair_type carry_in,
   output idut_pkg::carry_pair_type carry_out,
   output idut_pkg::digit_type      digit
);

   idut_pkg::digit_type digit_ff;
   idut_pkg::digit_type digit_in;
   idut_pkg::digit_type adjust_first;
   idut_pkg::digit_type middle;
   idut_pkg::digit_type adjust_second;
   idut_pkg::digit_type stepped;

   // First step takes the upper carry bit, the second step the lower one.
   always_comb begin
      adjust_first = (digit_ff >= idut_pkg::ADJUST_LIMIT) ?
                     digit_ff + idut_pkg::ADJUST_ADD : digit_ff;
      carry_out[1] = adjust_first[3];
      middle       = {adjust_first[2:0], carry_in[1]};

      adjust_second = (middle >= idut_pkg::ADJUST_LIMIT) ?
                      middle + idut_pkg::ADJUST_ADD : middle;
      carry_out[0]  = adjust_second[3];
      stepped       = {adjust_second[2:0], carry_in[0]};
   end

   // A new conversion starts from zero.
   always_comb begin
      if (clear) begin
         digit_in = '0;
      end else if (enable) begin
         digit_in = stepped;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

### rtl/idut_emitter.sv
// Text emitter: sends the prefix, dashes and stored decimal digits one character per cycle.
module idut_emitter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  idut_pkg::digit_row_type   digits,
   output idut_pkg::emit_status_type status,
   output logic                      rsp_strobe,
   output idut_pkg::char_type        rsp_text_char,
   output logic                      rsp_last_char
);

   logic                    active_ff;
   logic                    active_in;
   idut_pkg::pos_type       pos_ff;
   idut_pkg::pos_type       pos_in;
   idut_pkg::digit_row_type row_ff;
   idut_pkg::digit_row_type row_in;
   logic                    strobe_ff;
   logic                    strobe_in;
   idut_pkg::char_type      char_ff;
   idut_pkg::char_type      char_in;
   logic                    last_ff;
   logic                    last_in;
   logic                    take_digit;
   logic                    finishing;

   assign finishing = active_ff && (pos_ff == idut_pkg::TEXT_LAST);

   // Pick the character for the current position.
   always_comb begin
      take_digit = 1'b0;
      if (pos_ff < idut_pkg::PREFIX_END) begin
         char_in = idut_pkg::prefix_char(pos_ff);
      end else if ((pos_ff == idut_pkg::DIGIT_DASH_A) ||
                   (pos_ff == idut_pkg::DIGIT_DASH_B)) begin
         char_in = idut_pkg::ASCII_DASH;
      end else begin
         char_in    = idut_pkg::ASCII_ZERO +
                      idut_pkg::char_type'(row_ff[idut_pkg::DIGIT_BITS-1 -:
                                                  idut_pkg::DIGIT_WIDTH]);
         take_digit = active_ff;
      end
      strobe_in = active_ff;
      last_in   = finishing;
   end

   // Position counter and digit row; the most significant digit leaves first.
   always_comb begin
      if (load) begin
         active_in = 1'b1;
         pos_in    = '0;
         row_in    = digits;
      end else begin
         active_in = active_ff && !finishing;
         pos_in    = active_ff ? pos_ff + idut_pkg::pos_type'(1) : pos_ff;
         row_in    = take_digit ?
                     {row_ff[idut_pkg::DIGIT_BITS-idut_pkg::DIGIT_WIDTH-1:0],
                      idut_pkg::digit_type'(0)} : row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.active    = active_ff;
   assign status.finishing = finishing;
   assign rsp_strobe       = strobe_ff;
   assign rsp_text_char    = char_ff;
   assign rsp_last_char    = last_ff && strobe_ff;

endmodule

### rtl/index_to_decimal_uuid_text.sv
// Top level: 64-bit index to 36-character decimal UUID text, one character per result.
// After the accepting edge the row converts in the RUN state, and the HOLD state hands the digits to
//    the emitter once it is free; the emitter registers each of the 36 characters, one character each cycle.
// A new index is taken once the previous digits are handed over; the row of 20 digit cells then converts
//    it two bits at a step while the previous text goes out.
// Reset clears the sequencer, step counter and emitter; no result is pending afterward.
module index_to_decimal_uuid_text (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  idut_pkg::index_type req_index_value,
   output logic               rsp_strobe,
   output idut_pkg::char_type rsp_text_char,
   output logic               rsp_last_char
);

   idut_pkg::conv_state_type  state_ff;
   idut_pkg::conv_state_type  state_in;
   idut_pkg::step_type        step_ff;
   idut_pkg::step_type        step_in;
   idut_pkg::index_type       source_ff;
   idut_pkg::index_type       source_in;
   idut_pkg::emit_status_type emit_status;
   idut_pkg::digit_row_type   digit_row;
   idut_pkg::carry_pair_type  cell_carry [0:idut_pkg::DIGIT_COUNT];
   logic                      accept;
   logic                      cells_enable;
   logic                      emit_load;
   logic                      emit_free;

   assign emit_free = !emit_status.active || emit_status.finishing;
   assign accept    = start && !busy;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         idut_pkg::CONV_IDLE: begin
            if (start) begin
               state_in = idut_pkg::CONV_RUN;
            end
         end
         idut_pkg::CONV_RUN: begin
            if (step_ff == idut_pkg::STEP_LAST) begin
               state_in = idut_pkg::CONV_HOLD;
            end
         end
         idut_pkg::CONV_HOLD: begin
            if (emit_free) begin
               state_in = idut_pkg::CONV_IDLE;
            end
         end
         default: begin
            state_in = idut_pkg::CONV_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy         = 1'b1;
      cells_enable = 1'b0;
      emit_load    = 1'b0;
      unique case (state_ff)
         idut_pkg::CONV_IDLE: begin
            busy = 1'b0;
         end
         idut_pkg::CONV_RUN: begin
            cells_enable = 1'b1;
         end
         idut_pkg::CONV_HOLD: begin
            emit_load = emit_free;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Index shifter and step counter feed two bits a cycle into the cell row while converting.
   always_comb begin
      source_in = source_ff;
      step_in   = step_ff;
      if (accept) begin
         source_in = req_index_value;
         step_in   = '0;
      end else if (cells_enable) begin
         source_in = {source_ff[idut_pkg::INDEX_WIDTH-idut_pkg::BITS_PER_STEP-1:0],
                      idut_pkg::carry_pair_type'(0)};
         step_in   = step_ff + idut_pkg::step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idut_pkg::CONV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      source_ff <= source_in;
   end

   // Row of digit cells; the least significant cell takes the index bits.
   assign cell_carry[idut_pkg::DIGIT_COUNT] =
      source_ff[idut_pkg::INDEX_WIDTH-1 -: idut_pkg::BITS_PER_STEP];

   for (genvar d = 0; d < idut_pkg::DIGIT_COUNT; d++) begin : g_cell
      idut_cell u_cell (
         .clock     (clock),
         .clear     (accept),
         .enable    (cells_enable),
         .carry_in  (cell_carry[d+1]),
         .carry_out (cell_carry[d]),
         .digit     (digit_row[idut_pkg::DIGIT_BITS-1-d*idut_pkg::DIGIT_WIDTH -:
                               idut_pkg::DIGIT_WIDTH])
      );
   end

   idut_emitter u_emitter (
      .clock         (clock),
      .reset         (reset),
      .load          (emit_load),
      .digits        (digit_row),
      .status        (emit_status),
      .rsp_strobe    (rsp_strobe),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

   // The most significant cell never overflows while converting.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == idut_pkg::CONV_RUN) |-> (cell_carry[0] == '0))
      else $error("digit row overflowed out of the top cell");

   // After a handoff, the emitter registers the load and then a zero first character of the text.
   assert property (@(posedge clock) disable iff (reset)
      emit_load |-> ##2 (rsp_strobe && (rsp_text_char == idut_pkg::ASCII_ZERO)))
      else $error("text did not start after handoff");

   // Characters of one text leave in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_char) |=> rsp_strobe)
      else $error("gap inside a text");

   // The converter stays busy through a running or finished conversion and is released only after its handoff.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(emit_load))
      else $error("converter released without handoff");

endmodule

### tb/sv/index_to_decimal_uuid_text_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the index to decimal UUID text block, with its text scoreboard.

// One expected character of the text, in result port order.
typedef struct packed {
   idut_pkg::char_type text_char;
   logic               last_char;
} uuid_char_type;

// Builds the expected 36-character text of each accepted index and checks characters in order.
class uuid_text_scoreboard;
   uuid_char_type expected_text[$];
   int            index_count;
   int            char_count;
   int            mismatch_count;

   // Splits the index into 20 decimal digits and queues prefix, digit groups and dashes.
   function void note_index(idut_pkg::index_type index_value);
      logic [3:0]          digits [20];
      idut_pkg::index_type rest;
      uuid_char_type       entry;
      int                  k;
      rest = index_value;
      for (int i = 19; i >= 0; i--) begin
         digits[i] = 4'(rest % 64'd10);
         rest      = rest / 64'd10;
      end
      for (int pos = 0; pos < idut_pkg::TEXT_LENGTH; pos++) begin
         if (pos < idut_pkg::PREFIX_LENGTH) begin
            // The prefix is all zeros apart from its two dashes.
            if (pos == idut_pkg::PREFIX_DASH_A || pos == idut_pkg::PREFIX_DASH_B) begin
               entry.text_char = idut_pkg::ASCII_DASH;
            end else begin
               entry.text_char = idut_pkg::ASCII_ZERO;
            end
         end else begin
            // Digits are grouped 4, 4 and 12 with a dash after each of the first two groups.
            k = pos - idut_pkg::PREFIX_LENGTH;
            if (k == 4 || k == 9) begin
               entry.text_char = idut_pkg::ASCII_DASH;
            end else begin
               if (k > 9) begin
                  k = k - 2;
               end else if (k > 4) begin
                  k = k - 1;
               end
               entry.text_char = idut_pkg::ASCII_ZERO + idut_pkg::char_type'(digits[k]);
            end
         end
         entry.last_char = (pos == idut_pkg::TEXT_LENGTH - 1);
         expected_text.push_back(entry);
      end
      index_count++;
   endfunction

   // Prints one line per mismatch, up to a cap so a broken design does not flood the log.
   task report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 30) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
   endtask

   // Compares one character against the oldest expected one, field by field.
   task check_char(input idut_pkg::char_type got_char, input logic got_last);
      uuid_char_type want;
      if (expected_text.size() == 0) begin
         report_mismatch($sformatf("character %0d arrived with no text pending", got_char));
      end else begin
         want = expected_text.pop_front();
         char_count++;
         if (got_char !== want.text_char) begin
            report_mismatch($sformatf("character %0d: text_char %0d, expected %0d",
                                      char_count, got_char, want.text_char));
         end
         if (got_last !== want.last_char) begin
            report_mismatch($sformatf("character %0d: last_char %0b, expected %0b",
                                      char_count, got_last, want.last_char));
         end
      end
   endtask

   function int pending();
      return expected_text.size();
   endfunction
endclass

module index_to_decimal_uuid_text_tb;

   localparam int RANDOM_INDICES = 250;
   localparam int CYCLE_LIMIT    = 200000;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   idut_pkg::index_type req_index_value = '0;
   logic                busy;
   logic                rsp_strobe;
   idut_pkg::char_type  rsp_text_char;
   logic                rsp_last_char;

   uuid_text_scoreboard text_board = new();
   int                  cycle_count = 0;
   int                  directed_count;
   int                  random_count;

   idut_pkg::index_type directed_values [18] = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd9999, 64'd10000,
      64'd999999999999, 64'd1000000000000,
      64'd9999999999999999, 64'd10000000000000000,
      64'd9999999999999999999, 64'd10000000000000000000,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0000,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd12345678901234567890
   };

   index_to_decimal_uuid_text u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_index_value (req_index_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char)
   );

   always #5 clock = ~clock;

   // Every strobed character is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         text_board.check_char(rsp_text_char, rsp_last_char);
      end
   end

   // Watchdog against a hung design.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d characters outstanding.",
                  cycle_count, text_board.pending());
         $display("Some tests failed");
         $finish;
      end
   end

   // Holds an index on the request ports until the block takes it.
   task automatic send_index(input idut_pkg::index_type index_value);
      req_index_value <= index_value;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      text_board.note_index(index_value);
   endtask

   // Leaves the request side idle, with junk on the index port.
   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) begin
            req_index_value <= {$urandom, $urandom};
            @(posedge clock);
         end
      end
   endtask

   // Stops sending until every queued character has come out.
   task automatic drain_text();
      start <= 1'b0;
      @(posedge clock);
      while (text_board.pending() > 0) begin
         @(posedge clock);
      end
   endtask

   // Mix of full-range values, small values, values next to powers of ten and shifted values.
   function automatic idut_pkg::index_type random_index();
      idut_pkg::index_type power;
      int                  exponent;
      power = 64'd1;
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return idut_pkg::index_type'($urandom_range(0, 99999));
         2: begin
            exponent = $urandom_range(1, 19);
            repeat (exponent) power = power * 64'd10;
            return power + idut_pkg::index_type'($urandom_range(0, 4)) - 64'd2;
         end
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   initial begin
      int burst_length;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: field extremes, group boundaries and alternating bit patterns.
      foreach (directed_values[i]) begin
         send_index(directed_values[i]);
         if (i % 3 == 2) begin
            idle_for($urandom_range(1, 40));
         end
      end
      drain_text();
      directed_count = text_board.index_count;

      // Random part: bursts of indices with random gaps, full drains and back-to-back runs.
      random_count = 0;
      while (random_count < RANDOM_INDICES) begin
         burst_length = $urandom_range(1, 8);
         repeat (burst_length) begin
            send_index(random_index());
            random_count++;
         end
         case ($urandom_range(0, 9))
            0:       drain_text();
            1, 2, 3: ;
            default: idle_for($urandom_range(1, 45));
         endcase
      end

      // Let the last text finish and watch for stray characters afterward.
      drain_text();
      repeat (80) @(posedge clock);

      $display("Rendered %0d indices (%0d directed, %0d random) as UUID text.",
               text_board.index_count, directed_count, random_count);
      $display("Checked %0d characters; %0d mismatches.",
               text_board.char_count, text_board.mismatch_count);
      if (text_board.mismatch_count == 0 && text_board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
